// ===== hdl/spherical_cartesian_converter_top_defines.svh =====
// assertion macros used by the converter checker
`ifndef SPHERICAL_CARTESIAN_CONVERTER_TOP_DEFINES_SVH
`define SPHERICAL_CARTESIAN_CONVERTER_TOP_DEFINES_SVH

// clocked assertion, switched off while reset is held
`define SCC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("converter assertion failed");

// clocked assertion that also holds through reset
`define SCC_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("converter reset assertion failed");

`endif

// ===== hdl/scc_pkg.sv =====
// types, constants and arithmetic helpers of the coordinate converter
package scc_pkg;

    localparam int unsigned ATAN_N     = 32;
    localparam int unsigned SQRT_STEPS = 32;

    // arctangent of 2^-i as binary angle
    localparam logic [31:0] ATAN_TAB [ATAN_N] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    // gain-corrected start value, Q2.30
    localparam logic signed [63:0] CORDIC_X0  = 64'sd652032874;
    localparam logic [31:0]        QUARTER    = 32'h4000_0000;
    localparam logic [31:0]        HALF_TURN  = 32'h8000_0000;
    localparam logic [31:0]        THREE_QTR  = 32'hC000_0000;
    localparam logic [31:0]        POS_MAX    = 32'h7FFF_FFFF;
    localparam logic [31:0]        NEG_MIN    = 32'h8000_0000;
    localparam logic signed [63:0] RND_HALF   = 64'sd536870912;

    typedef struct packed {
        logic [63:0] v;
        logic [63:0] res;
    } t_root;

    typedef struct packed {
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic [31:0]        z;
        logic               rot;
        logic               flip;
        logic               byp;
    } t_lane;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic [63:0]        sq_a;
        logic [63:0]        sq_b;
        logic [63:0]        sq_c;
    } t_sq;

    typedef struct packed {
        logic               mode;
        logic               zero;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
    } t_carry;

    typedef struct packed {
        t_carry      cy;
        logic [63:0] sxy;
        logic [63:0] tot;
    } t_sum;

    typedef struct packed {
        logic               mode;
        logic               zero;
        logic               sat;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic [32:0]        rho;
        logic [31:0]        r;
    } t_rad;

    typedef struct packed {
        logic               mode;
        logic               zero;
        logic               sat;
        logic signed [31:0] a;
        logic [31:0]        r;
        t_lane              l0;
        t_lane              l1;
    } t_cor;

    typedef struct packed {
        logic               mode;
        logic               zero;
        logic               sat;
        logic signed [31:0] a;
        logic [31:0]        r;
        logic [31:0]        th;
        logic [31:0]        ph;
        logic signed [31:0] ct;
        logic signed [63:0] m1;
        logic signed [63:0] m2;
    } t_fin;

    typedef struct packed {
        logic               mode;
        logic               zero;
        logic               sat;
        logic signed [31:0] a;
        logic [31:0]        r;
        logic [31:0]        th;
        logic [31:0]        ph;
        logic signed [31:0] ct;
        logic signed [31:0] p1;
        logic signed [31:0] p2;
    } t_pr;

    typedef struct packed {
        logic               mode;
        logic               zero;
        logic               sat;
        logic [31:0]        r;
        logic [31:0]        th;
        logic [31:0]        ph;
        logic signed [63:0] ma;
        logic signed [63:0] mb;
        logic signed [63:0] mc;
    } t_mul;

    typedef struct packed {
        logic        sat;
        logic        deg;
        logic [31:0] oc;
        logic [31:0] ob;
        logic [31:0] oa;
    } t_res;

    // signed 32 x 32 product, full width
    function automatic logic signed [63:0] smul32(input logic signed [31:0] p,
                                                  input logic signed [31:0] q);
        smul32 = p * q;
    endfunction

    // round to nearest at bit 30
    function automatic logic signed [63:0] rnd30(input logic signed [63:0] v);
        rnd30 = (v + RND_HALF) >>> 30;
    endfunction

    // clamp to int32, flag in the top bit
    function automatic logic [32:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            sat32 = {1'b1, POS_MAX};
        end else if (v < -64'sd2147483648) begin
            sat32 = {1'b1, NEG_MIN};
        end else begin
            sat32 = {1'b0, v[31:0]};
        end
    endfunction

    // one restoring square root step
    function automatic t_root root_step(input t_root s, input logic [63:0] bitv);
        logic [63:0] trial;
        t_root       o;
        trial = s.res + bitv;
        if (s.v >= trial) begin
            o.v   = s.v - trial;
            o.res = (s.res >> 1) + bitv;
        end else begin
            o.v   = s.v;
            o.res = s.res >> 1;
        end
        return o;
    endfunction

    // rotation start for sine and cosine of a binary angle
    function automatic t_lane lane_rot(input logic [31:0] ang);
        logic [31:0] t;
        t_lane       o;
        t      = ang + QUARTER;
        o.flip = t[31];
        o.z    = t[31] ? (ang ^ HALF_TURN) : ang;
        o.x    = CORDIC_X0;
        o.y    = '0;
        o.rot  = 1'b1;
        o.byp  = 1'b0;
        return o;
    endfunction

    // vectoring start for atan2, operands scaled by 2^24
    function automatic t_lane lane_vec(input logic signed [33:0] yv,
                                       input logic signed [33:0] xv);
        logic signed [63:0] xs;
        logic signed [63:0] ys;
        t_lane              o;
        xs     = {{6{xv[33]}}, xv, 24'd0};
        ys     = {{6{yv[33]}}, yv, 24'd0};
        o.rot  = 1'b0;
        o.flip = 1'b0;
        o.byp  = (yv == 34'sd0);
        o.x    = xs;
        o.y    = ys;
        o.z    = '0;
        if (yv == 34'sd0) begin
            o.z = xv[33] ? HALF_TURN : '0;
        end else if (xv[33]) begin
            if (!yv[33]) begin
                o.x = ys;
                o.y = -xs;
                o.z = QUARTER;
            end else begin
                o.x = -ys;
                o.y = xs;
                o.z = THREE_QTR;
            end
        end
        return o;
    endfunction

    // one micro-rotation, shared by rotation and vectoring
    function automatic t_lane lane_step(input t_lane l, input logic [4:0] i);
        logic  sigma;
        t_lane o;
        o     = l;
        sigma = l.rot ? !l.z[31] : l.y[63];
        if (!l.byp) begin
            if (sigma) begin
                o.x = l.x - (l.y >>> i);
                o.y = l.y + (l.x >>> i);
                o.z = l.z - ATAN_TAB[i];
            end else begin
                o.x = l.x + (l.y >>> i);
                o.y = l.y - (l.x >>> i);
                o.z = l.z + ATAN_TAB[i];
            end
        end
        return o;
    endfunction

endpackage

// ===== hdl/spherical_cartesian_converter_top.sv =====
// spherical and cartesian point converter, pipelined cordic and square root
//
// Input stream: tdata holds in_a, in_b, in_c (Q16.16 or binary angles),
// tuser holds mode (0 = spherical to cartesian, 1 = cartesian to spherical).
// Output stream: tdata holds out_a, out_b, out_c, tuser holds degenerate
// and saturated.
// From the accepting edge to the output register an item passes one square
// stage, one sum stage, 32 square root stages, rounding and cordic setup,
// CORDIC_STAGES micro-rotation stages, then three stages of products and
// rounding. Both directions run through the same stages.
// Throughput is one item per cycle while the skid register is empty: the square
// root and cordic stages each hold one item, so it then takes an item each cycle.
// A stalled receiver keeps its item in the output register; one more item
// goes to a skid register, then the pipeline holds and the input ready stays
// low while the skid register is full. Nothing is lost or repeated.
// Reset clears all valid bits; payload registers are not reset.
module spherical_cartesian_converter_top
    import scc_pkg::*;
#(
    parameter int unsigned CORDIC_STAGES = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // in_a [31:0], in_b [63:32], in_c [95:64]
    input  logic [95:0] i_s_axis_tdata,
    // mode [0]
    input  logic [0:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // out_a [31:0], out_b [63:32], out_c [95:64]
    output logic [95:0] o_m_axis_tdata,
    // degenerate [0], saturated [1]
    output logic [1:0]  o_m_axis_tuser
);

    localparam int unsigned V_ROOT0 = 2;
    localparam int unsigned V_RAD   = V_ROOT0 + SQRT_STEPS;
    localparam int unsigned V_INI   = V_RAD + 1;
    localparam int unsigned V_FIN   = V_INI + 1 + CORDIC_STAGES;
    localparam int unsigned N_PIPE  = V_FIN + 3;

    logic              en;
    logic              p_v;
    logic [N_PIPE-1:0] r_v;

    t_sq    r_sq,  n_sq;
    t_sum   r_sum, n_sum;
    t_root  r_rx [SQRT_STEPS];
    t_root  r_rt [SQRT_STEPS];
    t_carry r_rc [SQRT_STEPS];
    t_rad   r_rad, n_rad;
    t_cor   r_ini, n_ini;
    t_cor   r_cor [CORDIC_STAGES];
    t_fin   r_fin, n_fin;
    t_pr    r_pr,  n_pr;
    t_mul   r_mul, n_mul;
    t_res   n_res, r_out, r_skid;
    logic   r_ov, r_sv;

    // whole pipeline moves unless the skid register is full
    assign en              = !r_sv;
    assign o_s_axis_tready = en;
    assign p_v             = en && r_v[N_PIPE-1];

    // valid bits travel with the items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[N_PIPE-2:0], i_s_axis_tvalid};
        end
    end

    // squares of the three inputs
    always_comb begin
        n_sq.mode = i_s_axis_tuser[0];
        n_sq.a    = i_s_axis_tdata[31:0];
        n_sq.b    = i_s_axis_tdata[63:32];
        n_sq.c    = i_s_axis_tdata[95:64];
        n_sq.sq_a = smul32(n_sq.a, n_sq.a);
        n_sq.sq_b = smul32(n_sq.b, n_sq.b);
        n_sq.sq_c = smul32(n_sq.c, n_sq.c);
    end

    // sums of squares and zero vector test
    always_comb begin
        n_sum.cy.mode = r_sq.mode;
        n_sum.cy.zero = (r_sq.a == 32'sd0) && (r_sq.b == 32'sd0) && (r_sq.c == 32'sd0);
        n_sum.cy.a    = r_sq.a;
        n_sum.cy.b    = r_sq.b;
        n_sum.cy.c    = r_sq.c;
        n_sum.sxy     = r_sq.sq_a + r_sq.sq_b;
        n_sum.tot     = r_sq.sq_a + r_sq.sq_b + r_sq.sq_c;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq  <= n_sq;
            r_sum <= n_sum;
        end
    end

    // square root, one result bit per stage
    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_root
        localparam logic [63:0] BITV = 64'd1 << (62 - 2 * j);
        t_root n_x, n_t;
        if (j == 0) begin : g_first
            always_comb begin
                n_x = root_step('{v: r_sum.sxy, res: 64'd0}, BITV);
                n_t = root_step('{v: r_sum.tot, res: 64'd0}, BITV);
            end
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_rc[j] <= r_sum.cy;
                end
            end
        end else begin : g_next
            always_comb begin
                n_x = root_step(r_rx[j-1], BITV);
                n_t = root_step(r_rt[j-1], BITV);
            end
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_rc[j] <= r_rc[j-1];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rx[j] <= n_x;
                r_rt[j] <= n_t;
            end
        end
    end

    // rounding of both roots and radius clamp
    always_comb begin
        logic [63:0] rho_w;
        logic [63:0] r_w;
        rho_w = r_rx[SQRT_STEPS-1].res
              + {63'd0, (r_rx[SQRT_STEPS-1].v > r_rx[SQRT_STEPS-1].res)};
        r_w   = r_rt[SQRT_STEPS-1].res
              + {63'd0, (r_rt[SQRT_STEPS-1].v > r_rt[SQRT_STEPS-1].res)};
        n_rad.mode = r_rc[SQRT_STEPS-1].mode;
        n_rad.zero = r_rc[SQRT_STEPS-1].zero;
        n_rad.a    = r_rc[SQRT_STEPS-1].a;
        n_rad.b    = r_rc[SQRT_STEPS-1].b;
        n_rad.c    = r_rc[SQRT_STEPS-1].c;
        n_rad.rho  = rho_w[32:0];
        n_rad.sat  = r_w > {32'd0, POS_MAX};
        n_rad.r    = n_rad.sat ? POS_MAX : r_w[31:0];
    end

    // cordic lane setup for either direction
    always_comb begin
        n_ini.mode = r_rad.mode;
        n_ini.zero = r_rad.zero;
        n_ini.sat  = r_rad.sat;
        n_ini.a    = r_rad.a;
        n_ini.r    = r_rad.r;
        if (r_rad.mode) begin
            n_ini.l0 = lane_vec($signed({1'b0, r_rad.rho}),
                                $signed({{2{r_rad.c[31]}}, r_rad.c}));
            n_ini.l1 = lane_vec($signed({{2{r_rad.b[31]}}, r_rad.b}),
                                $signed({{2{r_rad.a[31]}}, r_rad.a}));
        end else begin
            n_ini.l0 = lane_rot(r_rad.b);
            n_ini.l1 = lane_rot(r_rad.c);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rad <= n_rad;
            r_ini <= n_ini;
        end
    end

    // micro-rotation stages, two lanes each
    for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_cor
        t_cor src, n_c;
        if (j == 0) begin : g_first
            assign src = r_ini;
        end else begin : g_next
            assign src = r_cor[j-1];
        end
        always_comb begin
            n_c    = src;
            n_c.l0 = lane_step(src.l0, 5'(j));
            n_c.l1 = lane_step(src.l1, 5'(j));
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_cor[j] <= n_c;
            end
        end
    end

    // quadrant fix and sine products
    always_comb begin
        logic signed [63:0] cx0;
        logic signed [63:0] sy0;
        logic signed [63:0] cx1;
        logic signed [63:0] sy1;
        t_cor               c;
        c   = r_cor[CORDIC_STAGES-1];
        cx0 = c.l0.flip ? -c.l0.x : c.l0.x;
        sy0 = c.l0.flip ? -c.l0.y : c.l0.y;
        cx1 = c.l1.flip ? -c.l1.x : c.l1.x;
        sy1 = c.l1.flip ? -c.l1.y : c.l1.y;
        n_fin.mode = c.mode;
        n_fin.zero = c.zero;
        n_fin.sat  = c.sat;
        n_fin.a    = c.a;
        n_fin.r    = c.r;
        n_fin.th   = c.l0.z;
        n_fin.ph   = c.l1.z;
        n_fin.ct   = cx0[31:0];
        n_fin.m1   = smul32(sy0[31:0], cx1[31:0]);
        n_fin.m2   = smul32(sy0[31:0], sy1[31:0]);
    end

    // rounding of the sine products
    always_comb begin
        logic signed [63:0] q1;
        logic signed [63:0] q2;
        q1         = rnd30(r_fin.m1);
        q2         = rnd30(r_fin.m2);
        n_pr.mode  = r_fin.mode;
        n_pr.zero  = r_fin.zero;
        n_pr.sat   = r_fin.sat;
        n_pr.a     = r_fin.a;
        n_pr.r     = r_fin.r;
        n_pr.th    = r_fin.th;
        n_pr.ph    = r_fin.ph;
        n_pr.ct    = r_fin.ct;
        n_pr.p1    = q1[31:0];
        n_pr.p2    = q2[31:0];
    end

    // radius scaling
    always_comb begin
        n_mul.mode = r_pr.mode;
        n_mul.zero = r_pr.zero;
        n_mul.sat  = r_pr.sat;
        n_mul.r    = r_pr.r;
        n_mul.th   = r_pr.th;
        n_mul.ph   = r_pr.ph;
        n_mul.ma   = smul32(r_pr.a, r_pr.p1);
        n_mul.mb   = smul32(r_pr.a, r_pr.p2);
        n_mul.mc   = smul32(r_pr.a, r_pr.ct);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fin <= n_fin;
            r_pr  <= n_pr;
            r_mul <= n_mul;
        end
    end

    // final rounding, clamping and result select
    always_comb begin
        logic [32:0] ca;
        logic [32:0] cb;
        logic [32:0] cc;
        ca = sat32(rnd30(r_mul.ma));
        cb = sat32(rnd30(r_mul.mb));
        cc = sat32(rnd30(r_mul.mc));
        if (r_mul.mode) begin
            n_res.oa  = r_mul.zero ? '0 : r_mul.r;
            n_res.ob  = r_mul.zero ? '0 : r_mul.th;
            n_res.oc  = r_mul.zero ? '0 : r_mul.ph;
            n_res.deg = r_mul.zero;
            n_res.sat = r_mul.sat;
        end else begin
            n_res.oa  = ca[31:0];
            n_res.ob  = cb[31:0];
            n_res.oc  = cc[31:0];
            n_res.deg = 1'b0;
            n_res.sat = ca[32] | cb[32] | cc[32];
        end
    end

    // output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || i_m_axis_tready) begin
            r_ov <= r_sv || p_v;
            r_sv <= 1'b0;
        end else if (p_v) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || i_m_axis_tready) begin
            r_out <= r_sv ? r_skid : n_res;
        end
        if (r_ov && !i_m_axis_tready && p_v) begin
            r_skid <= n_res;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {r_out.oc, r_out.ob, r_out.oa};
    assign o_m_axis_tuser  = {r_out.sat, r_out.deg};

endmodule

// ===== hdl/scc_checker.sv =====
// port-level checks of the converter and their binding
`include "spherical_cartesian_converter_top_defines.svh"

module scc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [95:0] i_s_axis_tdata,
    input logic [0:0]  i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [95:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser
);

    // a stalled result stays offered
    `SCC_ASSERT(a_hold_valid, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)

    // a stalled result keeps its coordinates
    `SCC_ASSERT(a_hold_data, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))

    // a zero vector never also reports a clamp
    `SCC_ASSERT(a_flags_excl, i_clk, i_rst_n, o_m_axis_tvalid |-> !(o_m_axis_tuser[0] && o_m_axis_tuser[1]))

    // degenerate items carry an all-zero result
    `SCC_ASSERT(a_degen_zero, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tdata == 96'd0)

    // reset empties the output
    `SCC_ASSERT_RST(a_rst_empty, i_clk, !i_rst_n |=> !o_m_axis_tvalid)

endmodule

bind spherical_cartesian_converter_top scc_checker u_scc_checker (.*);

// ===== tb/sv/testbench.sv =====
// testbench for the spherical and cartesian point converter
module testbench;
    import scc_pkg::*;

    localparam int STAGES  = 24;
    localparam int LATENCY = STAGES + 40;
    localparam logic MODE_SPH2CART = 1'b0;
    localparam logic MODE_CART2SPH = 1'b1;
    localparam int unsigned ANGLE_HALF = 32'h8000_0000;

    typedef struct {
        logic        mode;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } t_point;

    typedef struct {
        logic [31:0] oa;
        logic [31:0] ob;
        logic [31:0] oc;
        logic        deg;
        logic        sat;
    } t_conv;

    typedef struct {
        t_point p;
        logic   known;
        t_conv  r;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [95:0] i_s_axis_tdata = '0;
    logic [0:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [95:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;

    t_conv pending_q[$];
    int    n_fail = 0;
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    int    hold_off = 0;

    spherical_cartesian_converter_top #(.CORDIC_STAGES(STAGES)) dut (.*);

    always #5 i_clk = ~i_clk;

    // arithmetic shift right, rounding towards minus infinity
    function automatic longint shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rnd_q30(longint v);
        return shr(v + (64'sd1 <<< 29), 30);
    endfunction

    function automatic longint clamp32(longint v, ref logic flag);
        if (v > 64'sd2147483647) begin
            flag = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            flag = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic void sin_cos(logic [31:0] ang, output longint cs, output longint sn);
        logic [31:0] a;
        logic [31:0] t;
        logic        flip;
        longint      x;
        longint      y;
        longint      z;
        longint      nx;
        a = ang;
        t = a + 32'h4000_0000;
        flip = t[31];
        if (flip) a = a ^ ANGLE_HALF;
        z = longint'(signed'(a));
        x = 652032874;
        y = 0;
        for (int i = 0; i < STAGES && i < 32; i++) begin
            if (z >= 0) begin
                nx = x - shr(y, i); y = y + shr(x, i); z = z - longint'(ATAN_TAB[i]);
            end else begin
                nx = x + shr(y, i); y = y - shr(x, i); z = z + longint'(ATAN_TAB[i]);
            end
            x = nx;
        end
        cs = flip ? -x : x;
        sn = flip ? -y : y;
    endfunction

    function automatic logic [31:0] vec_angle(longint y, longint x);
        logic [31:0] z;
        longint      t;
        longint      nx;
        z = 0;
        if (y == 0) return (x < 0) ? ANGLE_HALF : 32'd0;
        x = x * 16777216;
        y = y * 16777216;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = 32'h4000_0000;
            end else begin
                t = x; x = -y; y = t; z = 32'hC000_0000;
            end
        end
        for (int i = 0; i < STAGES && i < 32; i++) begin
            if (y >= 0) begin
                nx = x + shr(y, i); y = y - shr(x, i); z = z + ATAN_TAB[i];
            end else begin
                nx = x - shr(y, i); y = y + shr(x, i); z = z - ATAN_TAB[i];
            end
            x = nx;
        end
        return z;
    endfunction

    function automatic logic [63:0] root_rounded(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        if (v > res) res = res + 1;
        return res;
    endfunction

    function automatic t_conv convert_point(t_point p);
        t_conv  r;
        longint a;
        longint b;
        longint c;
        longint ct;
        longint st;
        longint cp;
        longint sp;
        logic [63:0] sxy;
        logic [63:0] rad;
        logic        sat;
        a = longint'(signed'(p.a));
        b = longint'(signed'(p.b));
        c = longint'(signed'(p.c));
        sat = 1'b0;
        r.deg = 1'b0;
        if (p.mode == MODE_SPH2CART) begin
            sin_cos(p.b, ct, st);
            sin_cos(p.c, cp, sp);
            r.oa = 32'(clamp32(rnd_q30(a * rnd_q30(st * cp)), sat));
            r.ob = 32'(clamp32(rnd_q30(a * rnd_q30(st * sp)), sat));
            r.oc = 32'(clamp32(rnd_q30(a * ct), sat));
        end else if (a == 0 && b == 0 && c == 0) begin
            r.oa = 0; r.ob = 0; r.oc = 0;
            r.deg = 1'b1;
        end else begin
            sxy = 64'(a * a) + 64'(b * b);
            rad = root_rounded(sxy + 64'(c * c));
            if (rad > 64'h7FFF_FFFF) begin
                sat = 1'b1;
                r.oa = 32'h7FFF_FFFF;
            end else begin
                r.oa = rad[31:0];
            end
            r.ob = vec_angle(longint'(root_rounded(sxy)), c);
            r.oc = vec_angle(b, a);
        end
        r.sat = sat;
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: return 32'($urandom_range(0, 8)) - 32'd4;
            3: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
            default: return $urandom();
        endcase
    endfunction

    // offer one item, honouring the sender idle rate
    task automatic send_point(t_point p, logic known, t_conv r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {p.c, p.b, p.a};
        i_s_axis_tuser  <= p.mode;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        if (known) pending_q.push_back(r);
        else pending_q.push_back(convert_point(p));
        @(negedge i_clk);
    endtask

    // sender goes idle until every result is back
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(negedge i_clk);
    endtask

    // receiver ready
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_conv e;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_q.size() == 0) begin
                $error("unexpected item %h", o_m_axis_tdata);
                n_fail++;
            end else begin
                e = pending_q.pop_front();
                if (o_m_axis_tdata[31:0] !== e.oa) begin
                    $error("out_a expected %h actual %h", e.oa, o_m_axis_tdata[31:0]);
                    n_fail++;
                end
                if (o_m_axis_tdata[63:32] !== e.ob) begin
                    $error("out_b expected %h actual %h", e.ob, o_m_axis_tdata[63:32]);
                    n_fail++;
                end
                if (o_m_axis_tdata[95:64] !== e.oc) begin
                    $error("out_c expected %h actual %h", e.oc, o_m_axis_tdata[95:64]);
                    n_fail++;
                end
                if (o_m_axis_tuser[0] !== e.deg) begin
                    $error("degenerate expected %b actual %b", e.deg, o_m_axis_tuser[0]);
                    n_fail++;
                end
                if (o_m_axis_tuser[1] !== e.sat) begin
                    $error("saturated expected %b actual %b", e.sat, o_m_axis_tuser[1]);
                    n_fail++;
                end
            end
        end
    end

    // directed rows: answers typed in only for the zero vector and the axes
    t_dir_row dir_rows[] = '{
        '{'{MODE_CART2SPH, 32'd0, 32'd0, 32'd0}, 1'b1, '{0, 0, 0, 1'b1, 1'b0}},
        '{'{MODE_CART2SPH, 32'd0, 32'd0, 32'h0001_0000}, 1'b1,
          '{32'h0001_0000, 0, 0, 1'b0, 1'b0}},
        '{'{MODE_CART2SPH, 32'd0, 32'd0, 32'hFFFF_0000}, 1'b1,
          '{32'h0001_0000, 32'h8000_0000, 0, 1'b0, 1'b0}},
        '{'{MODE_CART2SPH, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 1'b0, '{0, 0, 0, 0, 0}},
        '{'{MODE_CART2SPH, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b0, '{0, 0, 0, 0, 0}},
        '{'{MODE_CART2SPH, 32'hFFFF_0000, 32'd0, 32'd0}, 1'b0, '{0, 0, 0, 0, 0}},
        '{'{MODE_CART2SPH, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000}, 1'b0, '{0, 0, 0, 0, 0}},
        '{'{MODE_CART2SPH, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF}, 1'b0, '{0, 0, 0, 0, 0}},
        '{'{MODE_CART2SPH, 32'hFFFF_0000, 32'hFFFF_0000, 32'd0}, 1'b0, '{0, 0, 0, 0, 0}},
        '{'{MODE_SPH2CART, 32'd0, 32'h1234_5678, 32'h9ABC_DEF0}, 1'b1, '{0, 0, 0, 1'b0, 1'b0}},
        '{'{MODE_SPH2CART, 32'h0001_0000, 32'd0, 32'd0}, 1'b0, '{0, 0, 0, 0, 0}},
        '{'{MODE_SPH2CART, 32'h0001_0000, 32'h4000_0000, 32'h4000_0000}, 1'b0, '{0, 0, 0, 0, 0}},
        '{'{MODE_SPH2CART, 32'h7FFF_FFFF, 32'h8000_0000, 32'hC000_0000}, 1'b0, '{0, 0, 0, 0, 0}},
        '{'{MODE_SPH2CART, 32'h8000_0000, 32'd0, 32'h8000_0000}, 1'b0, '{0, 0, 0, 0, 0}},
        '{'{MODE_SPH2CART, 32'h8000_0000, 32'h2000_0000, 32'h2000_0000}, 1'b0, '{0, 0, 0, 0, 0}},
        '{'{MODE_SPH2CART, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '{0, 0, 0, 0, 0}},
        '{'{MODE_SPH2CART, 32'h7FFF_FFFF, 32'h6000_0000, 32'hBFFF_FFFF}, 1'b0, '{0, 0, 0, 0, 0}}
    };

    // stimulus
    initial begin
        t_point p;
        t_conv  dummy;
        dummy = '{0, 0, 0, 0, 0};
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (dir_rows[k]) send_point(dir_rows[k].p, dir_rows[k].known, dir_rows[k].r);
        drain();
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                3: begin send_idle_pct = 20; recv_stall_pct = 20; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; hold_off = 300; end
            endcase
            for (int n = 0; n < 306; n++) begin
                p.mode = $urandom_range(0, 1);
                p.a = rand_word();
                p.b = rand_word();
                p.c = rand_word();
                if (p.mode == MODE_CART2SPH && $urandom_range(0, 19) == 0) begin
                    p.a = 0;
                    p.b = 0;
                end
                send_point(p, 1'b0, dummy);
            end
            // sender pauses until everything is back
            drain();
        end
        repeat (LATENCY + 10) @(posedge i_clk);
        if (n_fail == 0 && pending_q.size() == 0)
            $display("spherical_cartesian_converter_top: match");
        else
            $display("spherical_cartesian_converter_top: mismatch");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("spherical_cartesian_converter_top: mismatch");
        $finish;
    end

endmodule
